// ===== sv/mcdp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the microcoded datapath step block.
// Used by mcdp_alu and microcoded_cpu_datapath_step; depends on nothing.

package mcdp_pkg;

	// Peripheral interrupt lines actually wired (1 to 8)
	localparam int PERIPHERALS = 8;
	localparam logic [7:0] PERIPH_MASK = 8'((1 << PERIPHERALS) - 1);

	// Instruction number loaded on a trap
	localparam logic [7:0] INTCAL = 8'd1;

	// Register file indexes
	localparam logic [3:0] R_NONE = 4'd0;
	localparam logic [3:0] R_A    = 4'd1;
	localparam logic [3:0] R_TMP  = 4'd2;
	localparam logic [3:0] R_H    = 4'd5;
	localparam logic [3:0] R_L    = 4'd6;
	localparam logic [3:0] R_CH   = 4'd7;
	localparam logic [3:0] R_CL   = 4'd8;
	localparam logic [3:0] R_AH   = 4'd9;
	localparam logic [3:0] R_AL   = 4'd10;
	localparam logic [3:0] R_SH   = 4'd13;
	localparam logic [3:0] R_SL   = 4'd14;
	localparam logic [3:0] R_IR   = 4'd15;

	// Control word single-bit fields
	localparam int CW_CNT_INC  = 12;
	localparam int CW_ADR_INC  = 13;
	localparam int CW_STK_INC  = 14;
	localparam int CW_STK_DEC  = 15;
	localparam int CW_ADR_CNT  = 16;
	localparam int CW_ADR_STK  = 17;
	localparam int CW_ADR_HL   = 18;
	localparam int CW_CNT_INT  = 19;
	localparam int CW_FLAG_IN  = 22;
	localparam int CW_RAM_WR   = 23;
	localparam int CW_RAM_RD   = 24;
	localparam int CW_END      = 25;
	localparam int CW_INT_EN   = 26;
	localparam int CW_OUT      = 27;
	localparam int CW_HALT     = 28;

	// Flag register bits
	localparam int ZERO_BIT  = 0;
	localparam int SIGN_BIT  = 1;
	localparam int CARRY_BIT = 2;

	typedef enum logic [1:0] {
		FOUT_NONE = 2'd0,
		FOUT_ZERO = 2'd1,
		FOUT_SIGN = 2'd2,
		FOUT_ALL  = 2'd3
	} flag_out_t;

	typedef enum logic [3:0] {
		ALU_NOP  = 4'd0,
		ALU_ADD  = 4'd1,
		ALU_SUB  = 4'd2,
		ALU_AND  = 4'd3,
		ALU_OR   = 4'd4,
		ALU_XOR  = 4'd5,
		ALU_NOT  = 4'd6,
		ALU_INC  = 4'd7,
		ALU_DEC  = 4'd8,
		ALU_SHR  = 4'd9,
		ALU_SHL  = 4'd10,
		ALU_ADC  = 4'd11,
		ALU_SBC  = 4'd12,
		ALU_ACI  = 4'd13,
		ALU_SCI  = 4'd14,
		ALU_ROR  = 4'd15
	} alu_op_t;

	typedef enum logic [0:0] {
		CFG_HANDLER = 1'b0,
		CFG_START   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] value;
		logic       carry;
	} alu_res_t;

endpackage

// ===== sv/mcdp_alu.sv =====
`timescale 1ns / 1ps
// Eight-bit ALU of the datapath: sixteen operations with carry in and out.
// Depends on mcdp_pkg for the operation codes and the result struct.

module mcdp_alu (
	input  mcdp_pkg::alu_op_t  op,
	input  logic [7:0]         acc,
	input  logic [7:0]         tmp,
	input  logic               carry_in,
	output mcdp_pkg::alu_res_t res
);

	logic [8:0] acc9;
	logic [8:0] tmp9;
	logic [8:0] cin9;
	logic [8:0] wide;

	assign acc9 = {1'b0, acc};
	assign tmp9 = {1'b0, tmp};
	assign cin9 = {8'd0, carry_in};

	always_comb begin
		wide = 9'd0;
		res.value = acc;
		res.carry = carry_in;
		case (op)
			mcdp_pkg::ALU_ADD: begin
				wide = acc9 + tmp9;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_SUB: begin
				wide = acc9 - tmp9;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_AND: res.value = acc & tmp;
			mcdp_pkg::ALU_OR:  res.value = acc | tmp;
			mcdp_pkg::ALU_XOR: res.value = acc ^ tmp;
			mcdp_pkg::ALU_NOT: res.value = ~acc;
			mcdp_pkg::ALU_INC: begin
				wide = acc9 + 9'd1;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_DEC: begin
				wide = acc9 - 9'd1;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_SHR: res = {1'b0, acc[7:1], acc[0]};
			// carry takes the bit shifted out at the top
			mcdp_pkg::ALU_SHL: res = {acc[6:0], 1'b0, acc[7]};
			mcdp_pkg::ALU_ADC: begin
				wide = acc9 + tmp9 + cin9;
				res = {wide[7:0], wide[8]};
			end
			// borrow out of the nine-bit difference is acc < tmp + carry
			mcdp_pkg::ALU_SBC: begin
				wide = acc9 - tmp9 - cin9;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_ACI: begin
				wide = acc9 + cin9;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_SCI: begin
				wide = acc9 - cin9;
				res = {wide[7:0], wide[8]};
			end
			mcdp_pkg::ALU_ROR: res = {carry_in, acc[7:1], acc[0]};
			default: res = {acc, carry_in};
		endcase
	end

endmodule

// ===== sv/microcoded_cpu_datapath_step.sv =====
`timescale 1ns / 1ps
// Top level of the microcoded 8-bit datapath: executes one control word per word.
// Depends on mcdp_pkg and mcdp_alu.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control word together with
//   the RAM byte read at the previously reported address and the newly raised
//   interrupt lines. Output channel (out_valid/out_ready) returns the next
//   micro address, the address pair, bus latch and strobes for that step.
//   The caller fetches the ROM word and RAM byte named by a result and sends
//   them back as the next input word.
//   Execution: a word accepted into the input register executes once the result
//   register is free, and its result is shown in the result register from then on.
//   Throughput: one word per cycle while out_ready is high; the execute path is a
//   single pass through the register file muxes, pair incrementers and 8-bit ALU.
//   Stall: when out_ready is low the result holds, the input register keeps
//   one more word, and in_ready drops until the result is taken.
//   Reset: arst_n clears the register file, flags, bus latch, micro counter,
//   pending raises and acknowledge, sets interrupt enable, and empties both
//   registers. The first executed word loads the counter pair with
//   program_start and the stack pair with program_start minus one.
//   Configuration: cfg_write with cfg_index 0 (handler address) or 1
//   (program start) and 16-bit cfg_data, taken on the clock edge.

module microcoded_cpu_datapath_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [28:0] control_word,
	input  logic [7:0]  ram_read_data,
	input  logic [7:0]  raise_set,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] next_micro_address,
	output logic [15:0] address_value,
	output logic        ram_write,
	output logic [7:0]  bus_value,
	output logic        out_strobe,
	output logic        halted,
	output logic        ack_valid,
	output logic [2:0]  ack_index
);

	// Configuration registers
	logic [15:0] handler_q;
	logic [15:0] start_q;

	// Input register
	logic        valid_s1;
	logic [28:0] cw_s1;
	logic [7:0]  ram_s1;
	logic [7:0]  raise_s1;

	// Architectural state
	logic [7:0] rf_q [16];
	logic [7:0] bus_q;
	logic [7:0] flags_q;
	logic [3:0] mc_q;
	logic       ie_q;
	logic [7:0] pend_q;
	logic       ackd_q;   // an acknowledged peripheral is outstanding
	logic [2:0] ackd_idx_q;
	logic       started_q;

	// Next-state values of one step
	logic [7:0] rf_n [16];
	logic [7:0] bus_n;
	logic [7:0] flags_n;
	logic [3:0] mc_n;
	logic       ie_n;
	logic [7:0] pend_n;
	logic       ackd_n;
	logic [2:0] ackd_idx_n;
	logic       hit;
	logic [2:0] hit_idx;

	logic                step;
	logic [3:0]          code_in;
	logic [3:0]          code_out;
	mcdp_pkg::alu_op_t   alu_op;
	mcdp_pkg::flag_out_t flag_out;
	mcdp_pkg::alu_res_t  alu_res;

	// Execute when a word is held and the result register frees up this cycle
	assign step     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step;

	assign code_in  = cw_s1[3:0];
	assign code_out = cw_s1[7:4];
	assign alu_op   = mcdp_pkg::alu_op_t'(cw_s1[11:8]);
	assign flag_out = mcdp_pkg::flag_out_t'(cw_s1[21:20]);

	// Accumulator and temp are never touched by the pair logic ahead of the ALU
	mcdp_alu u_alu (
		.op      (alu_op),
		.acc     (rf_q[mcdp_pkg::R_A]),
		.tmp     (rf_q[mcdp_pkg::R_TMP]),
		.carry_in(flags_q[mcdp_pkg::CARRY_BIT]),
		.res     (alu_res)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_q <= 16'd0;
			start_q   <= 16'd0;
		end else if (cfg_write) begin
			case (mcdp_pkg::cfg_reg_t'(cfg_index))
				mcdp_pkg::CFG_HANDLER: handler_q <= cfg_data;
				mcdp_pkg::CFG_START:   start_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// One microstep, in the order the machine defines
	always_comb begin
		rf_n       = rf_q;
		bus_n      = bus_q;
		flags_n    = flags_q;
		mc_n       = mc_q + 4'd1;
		ie_n       = ie_q;
		pend_n     = pend_q | (raise_s1 & mcdp_pkg::PERIPH_MASK);
		ackd_n     = ackd_q;
		ackd_idx_n = ackd_idx_q;
		hit        = 1'b0;
		hit_idx    = 3'd0;

		// first step after reset: seed counter and stack pairs
		if (!started_q) begin
			{rf_n[mcdp_pkg::R_CH], rf_n[mcdp_pkg::R_CL]} = start_q;
			{rf_n[mcdp_pkg::R_SH], rf_n[mcdp_pkg::R_SL]} = start_q - 16'd1;
		end

		// pair increments; stack inc and dec together cancel
		if (cw_s1[mcdp_pkg::CW_CNT_INC])
			{rf_n[mcdp_pkg::R_CH], rf_n[mcdp_pkg::R_CL]} =
				{rf_n[mcdp_pkg::R_CH], rf_n[mcdp_pkg::R_CL]} + 16'd1;
		if (cw_s1[mcdp_pkg::CW_ADR_INC])
			{rf_n[mcdp_pkg::R_AH], rf_n[mcdp_pkg::R_AL]} =
				{rf_n[mcdp_pkg::R_AH], rf_n[mcdp_pkg::R_AL]} + 16'd1;
		if (cw_s1[mcdp_pkg::CW_STK_INC] && !cw_s1[mcdp_pkg::CW_STK_DEC])
			{rf_n[mcdp_pkg::R_SH], rf_n[mcdp_pkg::R_SL]} =
				{rf_n[mcdp_pkg::R_SH], rf_n[mcdp_pkg::R_SL]} + 16'd1;
		if (cw_s1[mcdp_pkg::CW_STK_DEC] && !cw_s1[mcdp_pkg::CW_STK_INC])
			{rf_n[mcdp_pkg::R_SH], rf_n[mcdp_pkg::R_SL]} =
				{rf_n[mcdp_pkg::R_SH], rf_n[mcdp_pkg::R_SL]} - 16'd1;

		// bus sources: register, then flag, then RAM, then ALU; later wins
		if (code_out != mcdp_pkg::R_NONE)
			bus_n = rf_n[code_out];
		case (flag_out)
			mcdp_pkg::FOUT_NONE: ;
			mcdp_pkg::FOUT_ZERO: bus_n = {7'd0, flags_n[mcdp_pkg::ZERO_BIT]};
			mcdp_pkg::FOUT_SIGN: bus_n = {7'd0, flags_n[mcdp_pkg::SIGN_BIT]};
			mcdp_pkg::FOUT_ALL:  bus_n = flags_n;
			default: ;
		endcase

		// acknowledge the lowest pending raise while enabled
		if (cw_s1[mcdp_pkg::CW_INT_EN])
			ie_n = 1'b1;
		for (int p = 0; p < mcdp_pkg::PERIPHERALS; p++) begin
			if (!hit && pend_n[p]) begin
				hit     = 1'b1;
				hit_idx = 3'(p);
			end
		end
		hit = hit && ie_n;
		if (hit) begin
			pend_n[hit_idx] = 1'b0;
			ie_n            = 1'b0;
			ackd_n          = 1'b1;
			ackd_idx_n      = hit_idx;
		end

		if (cw_s1[mcdp_pkg::CW_RAM_RD])
			bus_n = ram_s1;

		if (alu_op != mcdp_pkg::ALU_NOP) begin
			bus_n = alu_res.value;
			flags_n[mcdp_pkg::CARRY_BIT] = alu_res.carry;
		end

		// latch the bus; accumulator loads refresh sign and zero
		if (code_in != mcdp_pkg::R_NONE)
			rf_n[code_in] = bus_n;
		if (code_in == mcdp_pkg::R_A) begin
			flags_n[mcdp_pkg::SIGN_BIT] = bus_n[7];
			flags_n[mcdp_pkg::ZERO_BIT] = (bus_n == 8'd0);
		end

		// direct pair moves, applied in order
		if (cw_s1[mcdp_pkg::CW_ADR_CNT])
			{rf_n[mcdp_pkg::R_AH], rf_n[mcdp_pkg::R_AL]} =
				{rf_n[mcdp_pkg::R_CH], rf_n[mcdp_pkg::R_CL]};
		if (cw_s1[mcdp_pkg::CW_ADR_STK])
			{rf_n[mcdp_pkg::R_AH], rf_n[mcdp_pkg::R_AL]} =
				{rf_n[mcdp_pkg::R_SH], rf_n[mcdp_pkg::R_SL]};
		if (cw_s1[mcdp_pkg::CW_ADR_HL])
			{rf_n[mcdp_pkg::R_AH], rf_n[mcdp_pkg::R_AL]} =
				{rf_n[mcdp_pkg::R_H], rf_n[mcdp_pkg::R_L]};
		if (cw_s1[mcdp_pkg::CW_CNT_INT])
			{rf_n[mcdp_pkg::R_CH], rf_n[mcdp_pkg::R_CL]} = handler_q;

		if (cw_s1[mcdp_pkg::CW_FLAG_IN])
			flags_n = bus_n;

		// end of instruction: restart micro counter, trap on a re-raise
		if (cw_s1[mcdp_pkg::CW_END]) begin
			mc_n = 4'd0;
			if (ackd_n && pend_n[ackd_idx_n]) begin
				rf_n[mcdp_pkg::R_IR] = mcdp_pkg::INTCAL;
				pend_n[ackd_idx_n]   = 1'b0;
				ackd_n               = 1'b0;
			end
		end
	end

	// Input register: hold the word until it executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cw_s1    <= control_word;
			ram_s1   <= ram_read_data;
			raise_s1 <= raise_set;
		end
	end

	// Architectural state advances once per executed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				rf_q[i] <= 8'd0;
			bus_q      <= 8'd0;
			flags_q    <= 8'd0;
			mc_q       <= 4'd0;
			ie_q       <= 1'b1;
			pend_q     <= 8'd0;
			ackd_q     <= 1'b0;
			ackd_idx_q <= 3'd0;
			started_q  <= 1'b0;
		end else if (step) begin
			rf_q       <= rf_n;
			bus_q      <= bus_n;
			flags_q    <= flags_n;
			mc_q       <= mc_n;
			ie_q       <= ie_n;
			pend_q     <= pend_n;
			ackd_q     <= ackd_n;
			ackd_idx_q <= ackd_idx_n;
			started_q  <= 1'b1;
		end
	end

	// Result register: drop valid once taken, reload on every step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			next_micro_address <= {flags_n[3:0], rf_n[mcdp_pkg::R_IR], mc_n};
			address_value      <= {rf_n[mcdp_pkg::R_AH], rf_n[mcdp_pkg::R_AL]};
			ram_write          <= cw_s1[mcdp_pkg::CW_RAM_WR];
			bus_value          <= bus_n;
			out_strobe         <= cw_s1[mcdp_pkg::CW_OUT];
			halted             <= cw_s1[mcdp_pkg::CW_HALT];
			ack_valid          <= hit;
			ack_index          <= hit ? hit_idx : 3'd0;
		end
	end

	// Register zero is never written
	a_rf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rf_q[0] == 8'd0)
		else $error("register file entry zero modified");

	// End of instruction restarts the micro counter
	a_end_mc: assert property (@(posedge clk) disable iff (!arst_n)
		step && cw_s1[mcdp_pkg::CW_END] |=> mc_q == 4'd0)
		else $error("micro counter not cleared at end of instruction");

	// An executed word always produces a visible result
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("executed word produced no result");

	// An acknowledge clears interrupt enable
	a_ack_ie: assert property (@(posedge clk) disable iff (!arst_n)
		step && hit |=> !ie_q)
		else $error("interrupt enable still set after acknowledge");

	// No acknowledge index without an acknowledge
	a_ack_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ack_valid |-> ack_index == 3'd0)
		else $error("acknowledge index set without acknowledge");

endmodule
